/* design/dbbs_pkg.sv */
package dbbs_pkg;

  localparam int CFG_W = 20;
  localparam int DIV_W = 49;
  localparam int SUM_W = 48;
  localparam int CNT_W = 20;

  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = 24'sh800000;
  localparam logic [CNT_W-1:0]   COUNT_MAX = 20'hFFFFF;

  localparam logic signed [20:0] PI_Q16 = 21'sd205887;
  localparam logic signed [25:0] TX_Q8  = 26'sd44800;
  localparam logic signed [25:0] TY_Q8  = 26'sd84099;
  localparam logic signed [25:0] TZ_Q8  = 26'sd179456;

  localparam logic [19:0] FOCAL_X_RST  = 20'd153600;
  localparam logic [19:0] FOCAL_Y_RST  = 20'd153600;
  localparam logic [19:0] CENTER_X_RST = 20'd163840;
  localparam logic [19:0] CENTER_Y_RST = 20'd92160;

  typedef enum logic [2:0] {
    KIND_POINT  = 3'd0,
    KIND_MIN    = 3'd1,
    KIND_MAX    = 3'd2,
    KIND_CENTRE = 3'd3,
    KIND_DIR    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_BOX_LEFT   = 3'd4,
    REG_BOX_TOP    = 3'd5,
    REG_BOX_RIGHT  = 3'd6,
    REG_BOX_BOTTOM = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MUL, S_DIVS, S_DIVW, S_UPD, S_PT, S_FRAME,
    S_MDS, S_MDW, S_ROB, S_CS, S_CW, S_O_MIN, S_O_MAX, S_O_CEN, S_O_DIR
  } state_t;

  typedef struct packed {
    logic       in_ready;
    logic       mul_go;
    logic       div_start;
    logic       div_mean;
    logic [1:0] axis;
    logic       store_bp;
    logic       store_mean;
    logic       update;
    logic       robot;
    logic       zero_robot;
    logic       cor_start;
    logic       store_angle;
    logic       out_load;
    kind_t      out_kind;
    logic       clear;
  } dp_cmd_t;

  typedef struct packed {
    logic in_take;
    logic keep;
    logic last;
    logic count_nz;
    logic div_done;
    logic cor_done;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'(S24_MAX)) r = S24_MAX;
    else if (v < 26'(S24_MIN)) r = S24_MIN;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] a;
    case (i)
      4'd0:    a = 16'd51472;
      4'd1:    a = 16'd30386;
      4'd2:    a = 16'd16055;
      4'd3:    a = 16'd8150;
      4'd4:    a = 16'd4091;
      4'd5:    a = 16'd2047;
      4'd6:    a = 16'd1024;
      4'd7:    a = 16'd512;
      4'd8:    a = 16'd256;
      4'd9:    a = 16'd128;
      4'd10:   a = 16'd64;
      4'd11:   a = 16'd32;
      4'd12:   a = 16'd16;
      4'd13:   a = 16'd8;
      4'd14:   a = 16'd4;
      default: a = 16'd2;
    endcase
    return a;
  endfunction

endpackage

/* design/dbbs_if.sv */
interface dbbs_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_col;
  logic [11:0] pixel_row;
  logic [15:0] depth_mm;
  logic        last_pixel;
  modport source (output valid, pixel_col, pixel_row, depth_mm, last_pixel, input ready);
  modport sink (input valid, pixel_col, pixel_row, depth_mm, last_pixel, output ready);
endinterface

interface dbbs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         result_kind;
  logic signed [23:0] value_x;
  logic signed [23:0] value_y;
  logic signed [23:0] value_z;
  logic [19:0]        point_count;
  logic               last_result;
  modport source (output valid, result_kind, value_x, value_y, value_z, point_count,
                  last_result, input ready);
  modport sink (input valid, result_kind, value_x, value_y, value_z, point_count,
                last_result, output ready);
endinterface

interface dbbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/depth_box_backprojection_stats_core.sv */
// channel   dir  carries
// in_ch     in   depth pixel request: pixel_col, pixel_row, depth_mm, last_pixel
// out_ch    out  result: result_kind, value_x/y/z, point_count, last_result
// cfg_ch    in   register write: index, data
//
// One pixel at a time. A kept pixel takes two passes of the shared radix-2 divider
// plus multiply and update. Once the frame holds a kept pixel, the last pixel adds
// three mean divisions and two 16-step CORDIC runs.
// rst_n is synchronous; config registers and statistics return to their reset values.
// A stalled output holds the block in its emit state; the input waits meanwhile.
module depth_box_backprojection_stats_core import dbbs_pkg::*; #(
  parameter int IMAGE_WIDTH  = 1280,
  parameter int IMAGE_HEIGHT = 720,
  parameter int MAX_DEPTH_MM = 3000
) (
  input  logic       clk,
  input  logic       rst_n,
  dbbs_in_if.sink    in_ch,
  dbbs_out_if.source out_ch,
  dbbs_cfg_if.sink   cfg_ch
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  dbbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  dbbs_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .MAX_DEPTH_MM (MAX_DEPTH_MM)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

/* design/dbbs_div.sv */
module dbbs_div import dbbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [19:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [19:0]      rem_r, rem_nxt;
  logic [19:0]      dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [20:0]      rem_sh;
  logic             qbit;

  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};
  assign qbit   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = qbit ? 20'(rem_sh - {1'b0, dvs_r}) : rem_sh[19:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    // a zero divisor counts as one
    if (start) dvs_r <= (divisor == '0) ? 20'd1 : divisor;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

/* design/dbbs_cordic.sv */
module dbbs_cordic import dbbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [24:0] y_in,
  input  logic signed [24:0] x_in,
  output logic               done,
  output logic signed [23:0] angle
);

  logic signed [27:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [20:0] z_r, z_nxt;
  logic [3:0]         it_r, it_nxt;
  logic               run_r, run_nxt, done_r, done_nxt, zero_r, zero_nxt;
  logic signed [27:0] xs, ys, xe, ye;
  logic signed [20:0] at;
  logic signed [21:0] zr;

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign xe = 28'(x_in);
  assign ye = 28'(y_in);
  assign at = 21'($signed({1'b0, atan_q16(it_r)}));

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; it_nxt = it_r;
    run_nxt = run_r; done_nxt = 1'b0; zero_nxt = zero_r;
    if (start) begin
      zero_nxt = (x_in == '0) && (y_in == '0);
      it_nxt   = '0;
      run_nxt  = 1'b1;
      if (x_in < 0) begin
        // turn by half a circle first
        z_nxt = (y_in >= 0) ? PI_Q16 : -PI_Q16;
        x_nxt = -xe;
        y_nxt = -ye;
      end else begin
        z_nxt = '0;
        x_nxt = xe;
        y_nxt = ye;
      end
    end else if (run_r) begin
      if (!y_r[27]) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
      end
      it_nxt = it_r + 1'b1;
      if (it_r == 4'd15) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    it_r   <= it_nxt;
    zero_r <= zero_nxt;
  end

  assign zr    = (22'(z_r) + 22'sd4) >>> 3;
  assign done  = done_r;
  assign angle = zero_r ? 24'sd0 : 24'(zr);

endmodule

/* design/dbbs_dp.sv */
module dbbs_dp import dbbs_pkg::*; #(
  parameter int IMAGE_WIDTH  = 1280,
  parameter int IMAGE_HEIGHT = 720,
  parameter int MAX_DEPTH_MM = 3000
) (
  input  logic       clk,
  input  logic       rst_n,
  dbbs_in_if.sink    in_ch,
  dbbs_out_if.source out_ch,
  dbbs_cfg_if.sink   cfg_ch,
  input  dp_cmd_t    cmd,
  output dp_status_t sts
);

  logic [19:0]        focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [12:0] box_left_r, box_top_r, box_right_r, box_bottom_r;

  logic [11:0] col_r, row_r;
  logic [15:0] depth_r;
  logic        last_r;

  logic [35:0]        prod_r;
  logic               diff_pos_r, neg_r;
  logic signed [23:0] px_r, py_r, xm_r, ym_r, zm_r;
  logic signed [23:0] rx_r, ry_r, rz_r, yaw_r, pitch_r;

  logic signed [23:0] min_x_r, min_y_r, min_z_r, max_x_r, max_y_r, max_z_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic [CNT_W-1:0]   count_r;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic signed [23:0] out_x_r, out_y_r, out_z_r;
  logic [19:0]        out_count_r;
  logic               out_last_r;

  logic               in_take;
  logic signed [12:0] col_s, row_s;
  logic [11:0]        pos;
  logic [19:0]        centre, focal;
  logic signed [20:0] diff;
  logic [19:0]        diff_mag;
  logic signed [23:0] pz;
  logic signed [SUM_W-1:0] sum_sel, sum_mag;
  logic [DIV_W-1:0]   dividend, quot;
  logic [19:0]        divisor;
  logic               div_done, big;
  logic signed [23:0] qres;
  logic signed [24:0] cor_y, cor_x;
  logic               cor_done;
  logic signed [23:0] angle;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = cmd.in_ready;
  assign in_take      = in_ch.valid && cmd.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r    <= FOCAL_X_RST;
      focal_y_r    <= FOCAL_Y_RST;
      center_x_r   <= CENTER_X_RST;
      center_y_r   <= CENTER_Y_RST;
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_right_r  <= '0;
      box_bottom_r <= '0;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_FOCAL_X:    focal_x_r    <= cfg_ch.data;
        REG_FOCAL_Y:    focal_y_r    <= cfg_ch.data;
        REG_CENTER_X:   center_x_r   <= cfg_ch.data;
        REG_CENTER_Y:   center_y_r   <= cfg_ch.data;
        REG_BOX_LEFT:   box_left_r   <= cfg_ch.data[12:0];
        REG_BOX_TOP:    box_top_r    <= cfg_ch.data[12:0];
        REG_BOX_RIGHT:  box_right_r  <= cfg_ch.data[12:0];
        REG_BOX_BOTTOM: box_bottom_r <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  assign col_s = $signed({1'b0, col_r});
  assign row_s = $signed({1'b0, row_r});

  assign sts.in_take  = in_take;
  assign sts.last     = last_r;
  assign sts.keep     = (col_s >= box_left_r) && (col_s < box_right_r) &&
                        (row_s >= box_top_r) && (row_s < box_bottom_r) &&
                        ({1'b0, col_r} < 13'(IMAGE_WIDTH)) &&
                        ({1'b0, row_r} < 13'(IMAGE_HEIGHT)) &&
                        (depth_r != '0) && ({1'b0, depth_r} <= 17'(MAX_DEPTH_MM));
  assign sts.count_nz = count_r != '0;
  assign sts.div_done = div_done;
  assign sts.cor_done = cor_done;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // back-projection operands
  assign pos      = cmd.axis[0] ? row_r : col_r;
  assign centre   = cmd.axis[0] ? center_y_r : center_x_r;
  assign focal    = cmd.axis[0] ? focal_y_r : focal_x_r;
  assign diff     = $signed({1'b0, pos, 8'b0}) - $signed({1'b0, centre});
  assign diff_mag = diff[20] ? 20'(-diff) : diff[19:0];
  assign pz       = depth_r[15] ? S24_MAX : $signed({depth_r, 8'b0});

  always_comb begin
    case (cmd.axis)
      2'd0:    sum_sel = sum_x_r;
      2'd1:    sum_sel = sum_y_r;
      default: sum_sel = sum_z_r;
    endcase
  end
  assign sum_mag  = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
  assign dividend = cmd.div_mean ?
                    DIV_W'(sum_mag) + DIV_W'(count_r >> 1) : DIV_W'({prod_r, 8'b0});
  assign divisor  = cmd.div_mean ? count_r : focal;

  dbbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot)
  );

  assign big  = |quot[DIV_W-1:23];
  assign qres = neg_r ? (big ? S24_MIN : -$signed(quot[23:0]))
                      : (big ? S24_MAX : $signed(quot[23:0]));

  assign cor_y = cmd.axis[0] ? -25'(ry_r) : 25'(rx_r);
  assign cor_x = 25'(rz_r);

  dbbs_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (angle)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      col_r   <= in_ch.pixel_col;
      row_r   <= in_ch.pixel_row;
      depth_r <= in_ch.depth_mm;
      last_r  <= in_ch.last_pixel;
    end
    if (cmd.mul_go) begin
      prod_r     <= diff_mag * depth_r;
      diff_pos_r <= !diff[20] && (diff != '0);
    end
    if (cmd.div_start) neg_r <= cmd.div_mean ? sum_sel[SUM_W-1] : diff_pos_r;
    if (cmd.store_bp) begin
      if (cmd.axis[0]) py_r <= qres;
      else px_r <= qres;
    end
    if (cmd.store_mean) begin
      case (cmd.axis)
        2'd0:    xm_r <= qres;
        2'd1:    ym_r <= qres;
        default: zm_r <= qres;
      endcase
    end
    if (cmd.robot) begin
      rx_r <= sat24(26'(xm_r) + TX_Q8);
      ry_r <= sat24(26'(zm_r) - TY_Q8);
      rz_r <= sat24(TZ_Q8 - 26'(ym_r));
    end else if (cmd.zero_robot) begin
      rx_r <= '0; ry_r <= '0; rz_r <= '0;
    end
    if (cmd.zero_robot) begin
      yaw_r <= '0; pitch_r <= '0;
    end else if (cmd.store_angle) begin
      if (cmd.axis[0]) pitch_r <= angle;
      else yaw_r <= angle;
    end
  end

  // frame statistics
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      min_x_r <= S24_MAX; min_y_r <= S24_MAX; min_z_r <= S24_MAX;
      max_x_r <= S24_MIN; max_y_r <= S24_MIN; max_z_r <= S24_MIN;
      sum_x_r <= '0; sum_y_r <= '0; sum_z_r <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      if (px_r < min_x_r) min_x_r <= px_r;
      if (py_r < min_y_r) min_y_r <= py_r;
      if (pz < min_z_r) min_z_r <= pz;
      if (px_r > max_x_r) max_x_r <= px_r;
      if (py_r > max_y_r) max_y_r <= py_r;
      if (pz > max_z_r) max_z_r <= pz;
      // hold sums and count once the count is full
      if (count_r != COUNT_MAX) begin
        sum_x_r <= sum_x_r + SUM_W'(px_r);
        sum_y_r <= sum_y_r + SUM_W'(py_r);
        sum_z_r <= sum_z_r + SUM_W'(pz);
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (cmd.out_load) begin
      out_kind_r  <= cmd.out_kind;
      out_count_r <= count_r;
      out_last_r  <= cmd.out_kind == KIND_DIR;
      case (cmd.out_kind)
        KIND_POINT:  begin out_x_r <= px_r;    out_y_r <= py_r;    out_z_r <= pz;      end
        KIND_MIN:    begin out_x_r <= min_x_r; out_y_r <= min_y_r; out_z_r <= min_z_r; end
        KIND_MAX:    begin out_x_r <= max_x_r; out_y_r <= max_y_r; out_z_r <= max_z_r; end
        KIND_CENTRE: begin out_x_r <= rx_r;    out_y_r <= ry_r;    out_z_r <= rz_r;    end
        default:     begin out_x_r <= yaw_r;   out_y_r <= pitch_r; out_z_r <= '0;      end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.value_x     = out_x_r;
  assign out_ch.value_y     = out_y_r;
  assign out_ch.value_z     = out_z_r;
  assign out_ch.point_count = out_count_r;
  assign out_ch.last_result = out_last_r;

endmodule

/* design/dbbs_ctrl.sv */
module dbbs_ctrl import dbbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      S_IDLE:  if (sts.in_take) state_nxt = S_CHECK;
      S_CHECK: begin
        axis_nxt = 2'd0;
        if (sts.keep) state_nxt = S_MUL;
        else if (sts.last) state_nxt = S_FRAME;
        else state_nxt = S_IDLE;
      end
      S_MUL:   state_nxt = S_DIVS;
      S_DIVS:  state_nxt = S_DIVW;
      S_DIVW:  if (sts.div_done) begin
        if (axis_r == 2'd0) begin
          axis_nxt  = 2'd1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD:   state_nxt = S_PT;
      S_PT:    if (sts.out_free) state_nxt = sts.last ? S_FRAME : S_IDLE;
      S_FRAME: begin
        axis_nxt  = 2'd0;
        state_nxt = sts.count_nz ? S_MDS : S_O_MIN;
      end
      S_MDS:   state_nxt = S_MDW;
      S_MDW:   if (sts.div_done) begin
        if (axis_r == 2'd2) begin
          state_nxt = S_ROB;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MDS;
        end
      end
      S_ROB:   begin
        axis_nxt  = 2'd0;
        state_nxt = S_CS;
      end
      S_CS:    state_nxt = S_CW;
      S_CW:    if (sts.cor_done) begin
        if (axis_r == 2'd0) begin
          axis_nxt  = 2'd1;
          state_nxt = S_CS;
        end else begin
          state_nxt = S_O_MIN;
        end
      end
      S_O_MIN: if (sts.out_free) state_nxt = S_O_MAX;
      S_O_MAX: if (sts.out_free) state_nxt = S_O_CEN;
      S_O_CEN: if (sts.out_free) state_nxt = S_O_DIR;
      S_O_DIR: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.axis     = axis_r;
    cmd.out_kind = KIND_POINT;
    case (state_r)
      S_IDLE:  cmd.in_ready = 1'b1;
      S_MUL:   cmd.mul_go = 1'b1;
      S_DIVS:  cmd.div_start = 1'b1;
      S_DIVW:  cmd.store_bp = sts.div_done;
      S_UPD:   cmd.update = 1'b1;
      S_PT:    cmd.out_load = sts.out_free;
      S_FRAME: cmd.zero_robot = !sts.count_nz;
      S_MDS:   begin
        cmd.div_start = 1'b1;
        cmd.div_mean  = 1'b1;
      end
      S_MDW:   cmd.store_mean = sts.div_done;
      S_ROB:   cmd.robot = 1'b1;
      S_CS:    cmd.cor_start = 1'b1;
      S_CW:    cmd.store_angle = sts.cor_done;
      S_O_MIN: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_MIN;
      end
      S_O_MAX: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_MAX;
      end
      S_O_CEN: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_CENTRE;
      end
      S_O_DIR: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_DIR;
        cmd.clear    = sts.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

/* design/dbbs_checker.sv */
module dbbs_checker import dbbs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [23:0] out_x,
  input logic [19:0] out_count,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_x))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second pixel taken while busy");

  a_last_is_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == KIND_DIR)))
    else $error("frame end flag on wrong result");

  a_point_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_POINT |-> out_count != '0)
    else $error("point with zero count");

endmodule

bind depth_box_backprojection_stats_core dbbs_checker u_dbbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_x     (out_ch.value_x),
  .out_count (out_ch.point_count),
  .out_last  (out_ch.last_result)
);

/* tb/depth_box_backprojection_stats_core_tb.sv */
module depth_box_backprojection_stats_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbbs_pkg::*;

  localparam int IMG_W = 1280;
  localparam int IMG_H = 720;
  localparam int DEPTH_LIMIT = 3000;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam longint PI_A = 205887;
  localparam longint ATAN_TAB [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    kind_t              kind;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic [19:0]        count;
    logic               last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dbbs_in_if  in_ch ();
  dbbs_out_if out_ch ();
  dbbs_cfg_if cfg_ch ();

  depth_box_backprojection_stats_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // predictor state
  longint focal_x_q, focal_y_q, centre_x_q, centre_y_q;
  longint box_l, box_t, box_r, box_b;
  longint min_v [3];
  longint max_v [3];
  longint sum_v [3];
  longint kept_count;
  frame_result_t pending_q [$];

  int errors = 0;
  int n_pixels = 0;
  int n_results = 0;
  int n_frames = 0;
  bit quiet = 1'b0;
  bit want_hold = 1'b0;
  bit hold_done;
  int stall_left;
  int idle_cycles = 0;

  function automatic longint sat24l(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint back_project(longint pos, longint centre, longint focal,
                                          longint depth);
    longint diff, mag, q;
    diff = pos * 256 - centre;
    mag = (diff < 0 ? -diff : diff) * depth * 256;
    q = mag / (focal == 0 ? 1 : focal);
    if (q > 8388608) q = 8388608;
    return sat24l(diff > 0 ? -q : q);
  endfunction

  function automatic longint cordic_angle(longint yv, longint xv);
    longint za, xs, ys;
    za = 0;
    if (xv == 0 && yv == 0) return 0;
    // turn by pi into the right half plane
    if (xv < 0) begin
      za = (yv >= 0) ? PI_A : -PI_A;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < 16; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv += ys; yv -= xs; za += ATAN_TAB[i];
      end else begin
        xv -= ys; yv += xs; za -= ATAN_TAB[i];
      end
    end
    return (za + 4) >>> 3;
  endfunction

  function automatic longint rounded_mean(longint s, longint c);
    longint mag, q;
    mag = s < 0 ? -s : s;
    q = (mag + c / 2) / c;
    return sat24l(s < 0 ? -q : q);
  endfunction

  function automatic void push_expected(kind_t k, longint x, longint y, longint z,
                                        logic last);
    frame_result_t r;
    r.kind = k;
    r.vx = x[23:0];
    r.vy = y[23:0];
    r.vz = z[23:0];
    r.count = kept_count[19:0];
    r.last = last;
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void clear_frame_stats();
    for (int a = 0; a < 3; a++) begin
      min_v[a] = 8388607;
      max_v[a] = -8388608;
      sum_v[a] = 0;
    end
    kept_count = 0;
  endfunction

  function automatic void reset_predictor();
    focal_x_q = 153600; focal_y_q = 153600;
    centre_x_q = 163840; centre_y_q = 92160;
    box_l = 0; box_t = 0; box_r = 0; box_b = 0;
    clear_frame_stats();
  endfunction

  function automatic void predict_pixel(longint col, longint row, longint depth, bit last);
    longint p [3];
    longint rx, ry, rz, yaw, pitch;
    rx = 0; ry = 0; rz = 0; yaw = 0; pitch = 0;
    if (col >= box_l && col < box_r && row >= box_t && row < box_b &&
        col < IMG_W && row < IMG_H && depth >= 1 && depth <= DEPTH_LIMIT) begin
      p[0] = back_project(col, centre_x_q, focal_x_q, depth);
      p[1] = back_project(row, centre_y_q, focal_y_q, depth);
      p[2] = sat24l(depth * 256);
      for (int a = 0; a < 3; a++) begin
        if (p[a] < min_v[a]) min_v[a] = p[a];
        if (p[a] > max_v[a]) max_v[a] = p[a];
      end
      // sums and count hold once the count is full
      if (kept_count < 1048575) begin
        for (int a = 0; a < 3; a++) sum_v[a] += p[a];
        kept_count++;
      end
      push_expected(KIND_POINT, p[0], p[1], p[2], 1'b0);
    end
    if (last) begin
      if (kept_count > 0) begin
        rx = sat24l(rounded_mean(sum_v[0], kept_count) + 44800);
        ry = sat24l(rounded_mean(sum_v[2], kept_count) - 84099);
        rz = sat24l(179456 - rounded_mean(sum_v[1], kept_count));
        yaw = cordic_angle(rx, rz);
        pitch = cordic_angle(-ry, rz);
      end
      push_expected(KIND_MIN, min_v[0], min_v[1], min_v[2], 1'b0);
      push_expected(KIND_MAX, max_v[0], max_v[1], max_v[2], 1'b0);
      push_expected(KIND_CENTRE, rx, ry, rz, 1'b0);
      push_expected(KIND_DIR, yaw, pitch, 0, 1'b1);
      clear_frame_stats();
      n_frames++;
    end
  endfunction

  // result sink: random stalls, one long hold-off on request
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_q.size() == 0) begin
          $error("unexpected result kind=%0d", out_ch.result_kind);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (out_ch.result_kind !== e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, out_ch.result_kind);
            errors++;
          end
          if (out_ch.value_x !== e.vx) begin
            $error("value_x: expected %0d, got %0d", e.vx, out_ch.value_x);
            errors++;
          end
          if (out_ch.value_y !== e.vy) begin
            $error("value_y: expected %0d, got %0d", e.vy, out_ch.value_y);
            errors++;
          end
          if (out_ch.value_z !== e.vz) begin
            $error("value_z: expected %0d, got %0d", e.vz, out_ch.value_z);
            errors++;
          end
          if (out_ch.point_count !== e.count) begin
            $error("point_count: expected %0d, got %0d", e.count, out_ch.point_count);
            errors++;
          end
          if (out_ch.last_result !== e.last) begin
            $error("last_result: expected %0d, got %0d", e.last, out_ch.last_result);
            errors++;
          end
        end
      end
      if (want_hold && !hold_done) begin
        stall_left <= LONG_HOLD;
        hold_done <= 1'b1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // leaves valid high so back-to-back writes need no extra edge
  task automatic write_reg(reg_idx_t idx, logic [19:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_FOCAL_X:    focal_x_q = data;
      REG_FOCAL_Y:    focal_y_q = data;
      REG_CENTER_X:   centre_x_q = data;
      REG_CENTER_Y:   centre_y_q = data;
      REG_BOX_LEFT:   box_l = longint'($signed(data[12:0]));
      REG_BOX_TOP:    box_t = longint'($signed(data[12:0]));
      REG_BOX_RIGHT:  box_r = longint'($signed(data[12:0]));
      REG_BOX_BOTTOM: box_b = longint'($signed(data[12:0]));
      default: ;
    endcase
  endtask

  task automatic set_camera(int fx, int fy, int cx, int cy, int bl, int bt, int br, int bb);
    logic [6:0] junk;
    junk = 7'($urandom);
    write_reg(REG_FOCAL_X, 20'(fx));
    write_reg(REG_FOCAL_Y, 20'(fy));
    write_reg(REG_CENTER_X, 20'(cx));
    write_reg(REG_CENTER_Y, 20'(cy));
    // upper data bits are ignored by the box registers
    write_reg(REG_BOX_LEFT, {junk, 13'(bl)});
    write_reg(REG_BOX_TOP, {~junk, 13'(bt)});
    write_reg(REG_BOX_RIGHT, {junk, 13'(br)});
    write_reg(REG_BOX_BOTTOM, {~junk, 13'(bb)});
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(int col, int row, int depth, bit last);
    predict_pixel(col, row, depth, last);
    in_ch.valid <= 1'b1;
    in_ch.pixel_col <= 12'(col);
    in_ch.pixel_row <= 12'(row);
    in_ch.depth_mm <= 16'(depth);
    in_ch.last_pixel <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_pixels++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // hold the input until every expected result is back, then let a dropped pixel finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_empty_frame();
    send_pixel(100, 100, 500, 0);
    send_pixel(0, 0, 0, 1);
    drain();
  endtask

  task automatic test_field_extremes();
    set_camera(153600, 153600, 163840, 92160, -4096, -4096, 4095, 4095);
    send_pixel(0, 0, 1, 0);
    send_pixel(1279, 719, 3000, 0);
    send_pixel(1280, 0, 100, 0);
    send_pixel(0, 720, 100, 0);
    send_pixel(4095, 4095, 65535, 0);
    send_pixel(640, 360, 3001, 0);
    send_pixel(10, 10, 0, 0);
    send_pixel(640, 360, 1500, 1);
    drain();
  endtask

  task automatic test_intrinsic_extremes();
    set_camera(0, 0, 0, 1048575, 0, 0, IMG_W, IMG_H);
    send_pixel(1279, 719, 3000, 0);
    send_pixel(0, 0, 3000, 0);
    send_pixel(5, 5, 1, 1);
    drain();
    set_camera(1048575, 1048575, 1048575, 0, 0, 0, IMG_W, IMG_H);
    send_pixel(1279, 719, 3000, 0);
    send_pixel(0, 0, 2, 1);
    drain();
  endtask

  task automatic test_reversed_box();
    set_camera(153600, 153600, 163840, 92160, 900, 600, 100, 50);
    send_pixel(500, 300, 1000, 0);
    send_pixel(950, 620, 1000, 1);
    drain();
  endtask

  // a point whose robot x and z both come out zero gives a yaw of atan2 of zero by zero
  task automatic test_zero_direction();
    set_camera(65536, 65536, 0, 179456, 0, 0, 200, 10);
    send_pixel(175, 0, 256, 1);
    drain();
  endtask

  task automatic random_camera(bit wild);
    int fx, fy, bl, bt, br, bb;
    fx = $urandom_range(100, 2000) * 256;
    fy = $urandom_range(100, 2000) * 256;
    if (wild) begin
      fx = $urandom_range(0, 1048575);
      fy = $urandom_range(0, 1048575);
    end
    bl = $urandom_range(0, 1200); bt = $urandom_range(0, 650);
    br = bl + $urandom_range(1, 300); bb = bt + $urandom_range(1, 200);
    if (wild && $urandom_range(0, 1)) begin
      bl = $urandom_range(0, 8191) - 4096; br = $urandom_range(0, 8191) - 4096;
      bt = $urandom_range(0, 8191) - 4096; bb = $urandom_range(0, 8191) - 4096;
    end
    set_camera(fx, fy, wild ? $urandom_range(0, 1048575) : $urandom_range(0, 1280 * 256),
               wild ? $urandom_range(0, 1048575) : $urandom_range(0, 720 * 256),
               bl, bt, br, bb);
  endtask

  task automatic test_random_frames(int n_items, bit wild, bit hold);
    int col, row, depth, left;
    left = n_items;
    if (hold) want_hold <= 1'b1;
    while (left > 0) begin
      col = $urandom_range(0, 4095);
      row = $urandom_range(0, 4095);
      depth = $urandom_range(0, 65535);
      // mostly pixels inside the box with plausible depth
      if ($urandom_range(0, 9) < 8) begin
        if (box_r > box_l) col = $urandom_range(box_l < 0 ? 0 : box_l,
                                                box_r > 4096 ? 4095 : box_r - 1);
        if (box_b > box_t) row = $urandom_range(box_t < 0 ? 0 : box_t,
                                                box_b > 4096 ? 4095 : box_b - 1);
        if (col < 0) col = 0;
        if (row < 0) row = 0;
        if (col > 4095) col = 4095;
        if (row > 4095) row = 4095;
        depth = $urandom_range(1, DEPTH_LIMIT);
      end
      left--;
      send_pixel(col, row, depth, left == 0 || $urandom_range(0, 11) == 0);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pixel_col = '0;
    in_ch.pixel_row = '0;
    in_ch.depth_mm = '0;
    in_ch.last_pixel = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FOCAL_X;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_frame();
    test_field_extremes();
    test_intrinsic_extremes();
    test_reversed_box();
    test_zero_direction();

    random_camera(1'b0);
    test_random_frames(90, 1'b0, 1'b1);
    random_camera(1'b1);
    test_random_frames(60, 1'b1, 1'b0);
    random_camera(1'b0);
    test_random_frames(90, 1'b0, 1'b0);
    random_camera(1'b1);
    test_random_frames(60, 1'b1, 1'b0);
    random_camera(1'b0);
    test_random_frames(80, 1'b0, 1'b0);
    quiet = 1'b1;
    random_camera(1'b0);
    test_random_frames(80, 1'b0, 1'b0);

    $display("covered %0d pixels in %0d frames, %0d results checked", n_pixels, n_frames,
             n_results);
    $display("intrinsic and box extremes, empty frames and one long output hold included");
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
